// ===== hdl/overlapping_chunk_window_unit_assert.svh =====
// Assertion macros for the overlapping chunk window unit
`ifndef OVERLAPPING_CHUNK_WINDOW_UNIT_ASSERT_SVH
`define OVERLAPPING_CHUNK_WINDOW_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define OCW_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("ocw assertion failed");
`define OCW_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ocw implication failed");
`else
`define OCW_ASSERT(lbl, prop)
`define OCW_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// ===== hdl/ocw_pkg.sv =====
// Shared constants and types for the overlapping chunk window unit
package ocw_pkg;

    localparam int FRAME_BITS_DEF = 32;
    localparam int HOP_BITS_DEF   = 16;

    localparam int CHUNK_LENGTH_RST = 256;
    localparam int HOP_SIZE_RST     = 192;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_INTERNAL = 2'd2
    } t_status;

    typedef enum logic {
        REG_CHUNK_LENGTH = 1'b0,
        REG_HOP_SIZE     = 1'b1
    } t_reg_idx;

endpackage

// ===== hdl/ocw_cell.sv =====
// One cell of the chain: a restoring divide step and a shift-add multiply step
module ocw_cell #(
    parameter int FRAME_BITS = ocw_pkg::FRAME_BITS_DEF,
    parameter int HOP_BITS   = ocw_pkg::HOP_BITS_DEF,
    parameter int STEP       = 0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    input  logic [FRAME_BITS-1:0]        i_frames,
    input  logic [FRAME_BITS-1:0]        i_idx,
    input  logic [HOP_BITS-1:0]          i_len,
    input  logic [HOP_BITS-1:0]          i_hop,
    input  logic                         i_bad,
    input  logic                         i_fit,
    input  logic [FRAME_BITS-1:0]        i_dvd,
    input  logic [HOP_BITS-1:0]          i_rem,
    input  logic [FRAME_BITS-1:0]        i_quo,
    input  logic [FRAME_BITS+HOP_BITS-1:0] i_prod,
    output logic                         o_vld,
    output logic [FRAME_BITS-1:0]        o_frames,
    output logic [FRAME_BITS-1:0]        o_idx,
    output logic [HOP_BITS-1:0]          o_len,
    output logic [HOP_BITS-1:0]          o_hop,
    output logic                         o_bad,
    output logic                         o_fit,
    output logic [FRAME_BITS-1:0]        o_dvd,
    output logic [HOP_BITS-1:0]          o_rem,
    output logic [FRAME_BITS-1:0]        o_quo,
    output logic [FRAME_BITS+HOP_BITS-1:0] o_prod
);

    localparam int PW = FRAME_BITS + HOP_BITS;

    logic                  r_vld;
    logic [FRAME_BITS-1:0] r_frames;
    logic [FRAME_BITS-1:0] r_idx;
    logic [HOP_BITS-1:0]   r_len;
    logic [HOP_BITS-1:0]   r_hop;
    logic                  r_bad;
    logic                  r_fit;
    logic [FRAME_BITS-1:0] r_dvd;
    logic [HOP_BITS-1:0]   r_rem;
    logic [FRAME_BITS-1:0] r_quo;
    logic [PW-1:0]         r_prod;

    logic [FRAME_BITS-1:0] n_dvd;
    logic [HOP_BITS-1:0]   n_rem;
    logic [FRAME_BITS-1:0] n_quo;
    logic [PW-1:0]         n_prod;

    if (STEP < FRAME_BITS) begin : g_div
        logic [HOP_BITS:0] trial;
        logic              ge;
        always_comb begin
            trial = {i_rem, i_dvd[FRAME_BITS-1]};
            ge    = (trial >= {1'b0, i_hop});
            n_rem = ge ? HOP_BITS'(trial - {1'b0, i_hop}) : trial[HOP_BITS-1:0];
            n_quo = {i_quo[FRAME_BITS-2:0], ge};
            n_dvd = {i_dvd[FRAME_BITS-2:0], 1'b0};
        end
    end else begin : g_div_pass
        assign n_rem = i_rem;
        assign n_quo = i_quo;
        assign n_dvd = i_dvd;
    end

    if (STEP < HOP_BITS) begin : g_mul
        assign n_prod = i_prod + (i_hop[STEP] ? (PW'(i_idx) << STEP) : '0);
    end else begin : g_mul_pass
        assign n_prod = i_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frames <= i_frames;
        r_idx    <= i_idx;
        r_len    <= i_len;
        r_hop    <= i_hop;
        r_bad    <= i_bad;
        r_fit    <= i_fit;
        r_dvd    <= n_dvd;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_prod   <= n_prod;
    end

    assign o_vld    = r_vld;
    assign o_frames = r_frames;
    assign o_idx    = r_idx;
    assign o_len    = r_len;
    assign o_hop    = r_hop;
    assign o_bad    = r_bad;
    assign o_fit    = r_fit;
    assign o_dvd    = r_dvd;
    assign o_rem    = r_rem;
    assign o_quo    = r_quo;
    assign o_prod   = r_prod;

endmodule

// ===== hdl/overlapping_chunk_window_unit.sv =====
// Path from start to o_done: s0 register, cell chain, sa register, output register.
// Throughput: one transaction per cycle while busy is low; each cell does at most one
// quotient bit and one multiplier bit, so a new transaction enters every cycle.
// Reset: synchronous, active low; clears the pipeline valids, loads chunk_length 256
// and hop_size 192, and holds busy high for one cycle after release.
// o_done marks each result for one cycle; the receiver cannot stall it.
`include "overlapping_chunk_window_unit_assert.svh"
module overlapping_chunk_window_unit #(
    parameter int FRAME_BITS = ocw_pkg::FRAME_BITS_DEF,
    parameter int HOP_BITS   = ocw_pkg::HOP_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  ocw_pkg::t_reg_idx     i_cfg_idx,
    input  logic [HOP_BITS-1:0]   i_cfg_data,
    input  logic                  start,
    output logic                  busy,
    input  logic [FRAME_BITS-1:0] i_frame_count,
    input  logic [FRAME_BITS-1:0] i_chunk_index,
    output logic                  o_done,
    output logic [1:0]            o_status,
    output logic [FRAME_BITS-1:0] o_chunk_total,
    output logic [FRAME_BITS-1:0] o_window_start,
    output logic [HOP_BITS-1:0]   o_window_length
);
    import ocw_pkg::*;

    localparam int N   = (FRAME_BITS > HOP_BITS) ? FRAME_BITS : HOP_BITS;
    localparam int W   = N;
    localparam int PW  = FRAME_BITS + HOP_BITS;
    localparam int LAT = N + 3;

    logic [HOP_BITS-1:0] r_len_cfg;
    logic [HOP_BITS-1:0] r_hop_cfg;
    logic                r_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_cfg <= HOP_BITS'(CHUNK_LENGTH_RST);
            r_hop_cfg <= HOP_BITS'(HOP_SIZE_RST);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CHUNK_LENGTH: r_len_cfg <= i_cfg_data;
                REG_HOP_SIZE:     r_hop_cfg <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdy <= 1'b0;
        end else begin
            r_rdy <= 1'b1;
        end
    end

    assign busy = !r_rdy;

    logic accept;
    assign accept = start && !busy;

    logic                  r_s0_vld;
    logic [FRAME_BITS-1:0] r_s0_frames;
    logic [FRAME_BITS-1:0] r_s0_idx;
    logic [HOP_BITS-1:0]   r_s0_len;
    logic [HOP_BITS-1:0]   r_s0_hop;
    logic                  r_s0_bad;
    logic                  r_s0_fit;
    logic [FRAME_BITS-1:0] r_s0_dvd;

    logic                  n_s0_bad;
    logic                  n_s0_fit;
    logic [FRAME_BITS-1:0] n_s0_dvd;

    always_comb begin
        n_s0_bad = (i_frame_count == '0) || (r_len_cfg == '0) || (r_hop_cfg == '0)
                   || (r_hop_cfg >= r_len_cfg);
        n_s0_fit = (W'(i_frame_count) <= W'(r_len_cfg));
        n_s0_dvd = n_s0_fit ? '0 : FRAME_BITS'(W'(i_frame_count) - W'(r_len_cfg));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else begin
            r_s0_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_frames <= i_frame_count;
        r_s0_idx    <= i_chunk_index;
        r_s0_len    <= r_len_cfg;
        r_s0_hop    <= r_hop_cfg;
        r_s0_bad    <= n_s0_bad;
        r_s0_fit    <= n_s0_fit;
        r_s0_dvd    <= n_s0_dvd;
    end

    logic                  c_vld    [N+1];
    logic [FRAME_BITS-1:0] c_frames [N+1];
    logic [FRAME_BITS-1:0] c_idx    [N+1];
    logic [HOP_BITS-1:0]   c_len    [N+1];
    logic [HOP_BITS-1:0]   c_hop    [N+1];
    logic                  c_bad    [N+1];
    logic                  c_fit    [N+1];
    logic [FRAME_BITS-1:0] c_dvd    [N+1];
    logic [HOP_BITS-1:0]   c_rem    [N+1];
    logic [FRAME_BITS-1:0] c_quo    [N+1];
    logic [PW-1:0]         c_prod   [N+1];

    assign c_vld[0]    = r_s0_vld;
    assign c_frames[0] = r_s0_frames;
    assign c_idx[0]    = r_s0_idx;
    assign c_len[0]    = r_s0_len;
    assign c_hop[0]    = r_s0_hop;
    assign c_bad[0]    = r_s0_bad;
    assign c_fit[0]    = r_s0_fit;
    assign c_dvd[0]    = r_s0_dvd;
    assign c_rem[0]    = '0;
    assign c_quo[0]    = '0;
    assign c_prod[0]   = '0;

    for (genvar k = 0; k < N; k++) begin : g_cell
        ocw_cell #(
            .FRAME_BITS (FRAME_BITS),
            .HOP_BITS   (HOP_BITS),
            .STEP       (k)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_vld    (c_vld[k]),
            .i_frames (c_frames[k]),
            .i_idx    (c_idx[k]),
            .i_len    (c_len[k]),
            .i_hop    (c_hop[k]),
            .i_bad    (c_bad[k]),
            .i_fit    (c_fit[k]),
            .i_dvd    (c_dvd[k]),
            .i_rem    (c_rem[k]),
            .i_quo    (c_quo[k]),
            .i_prod   (c_prod[k]),
            .o_vld    (c_vld[k+1]),
            .o_frames (c_frames[k+1]),
            .o_idx    (c_idx[k+1]),
            .o_len    (c_len[k+1]),
            .o_hop    (c_hop[k+1]),
            .o_bad    (c_bad[k+1]),
            .o_fit    (c_fit[k+1]),
            .o_dvd    (c_dvd[k+1]),
            .o_rem    (c_rem[k+1]),
            .o_quo    (c_quo[k+1]),
            .o_prod   (c_prod[k+1])
        );
    end

    logic                  r_sa_vld;
    logic                  r_sa_bad;
    logic [FRAME_BITS-1:0] r_sa_idx;
    logic [HOP_BITS-1:0]   r_sa_len;
    logic [FRAME_BITS-1:0] r_sa_total;
    logic [FRAME_BITS-1:0] r_sa_begin;
    logic                  r_sa_past;
    logic [FRAME_BITS-1:0] r_sa_remain;

    logic [FRAME_BITS-1:0] n_sa_total;

    always_comb begin
        if (c_fit[N]) begin
            n_sa_total = FRAME_BITS'(1);
        end else begin
            n_sa_total = FRAME_BITS'(1) + c_quo[N] + FRAME_BITS'(c_rem[N] != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sa_vld <= 1'b0;
        end else begin
            r_sa_vld <= c_vld[N];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sa_bad    <= c_bad[N];
        r_sa_idx    <= c_idx[N];
        r_sa_len    <= c_len[N];
        r_sa_total  <= n_sa_total;
        r_sa_begin  <= c_prod[N][FRAME_BITS-1:0];
        r_sa_past   <= (c_prod[N] >= PW'(c_frames[N]));
        r_sa_remain <= c_frames[N] - c_prod[N][FRAME_BITS-1:0];
    end

    logic                  r_done;
    t_status               r_status;
    logic [FRAME_BITS-1:0] r_total;
    logic [FRAME_BITS-1:0] r_start;
    logic [HOP_BITS-1:0]   r_wlen;

    t_status               n_status;
    logic [FRAME_BITS-1:0] n_total;
    logic [FRAME_BITS-1:0] n_start;
    logic [HOP_BITS-1:0]   n_wlen;

    always_comb begin
        n_status = ST_OK;
        n_total  = '0;
        n_start  = '0;
        n_wlen   = '0;
        if (r_sa_bad || (r_sa_idx >= r_sa_total)) begin
            n_status = ST_INVALID;
        end else if (r_sa_past) begin
            n_status = ST_INTERNAL;
        end else begin
            n_total = r_sa_total;
            n_start = r_sa_begin;
            n_wlen  = (W'(r_sa_remain) < W'(r_sa_len)) ? HOP_BITS'(W'(r_sa_remain))
                                                         : r_sa_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_sa_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_total  <= n_total;
        r_start  <= n_start;
        r_wlen   <= n_wlen;
    end

    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_chunk_total   = r_total;
    assign o_window_start  = r_start;
    assign o_window_length = r_wlen;

    `OCW_ASSERT(a_latency, (start && !busy) |-> ##(LAT) o_done)
    `OCW_ASSERT_IMP(a_err_zero, o_done && (o_status != ST_OK), (o_chunk_total == '0) && (o_window_start == '0) && (o_window_length == '0))
    `OCW_ASSERT_IMP(a_ok_fields, o_done && (o_status == ST_OK), (o_chunk_total != '0) && (o_window_length != '0))

endmodule
